// ===== hw/rtl/wsf_pkg.sv =====
package wsf_pkg;

	localparam int COORD_W       = 16;
	localparam int NODE_W        = 4;
	localparam int OUT_W         = 20;
	localparam int NUM_FIELDS    = 10;
	localparam int IN_TDATA_W    = 48;
	localparam int OUT_TDATA_W   = 208;
	localparam int FRAC_BITS_DEF = 14;
	// coordinate magnitude bound in bits, used when one is smaller than it
	localparam int MIN_WIDE      = 17;
	localparam int OUT_MAX       = 524287;
	localparam int OUT_MIN       = -524288;

	// result field slots, lowest first
	localparam int FLD_SHAPE = 0;
	localparam int FLD_DR    = 1;
	localparam int FLD_DS    = 2;
	localparam int FLD_DT    = 3;
	localparam int FLD_DRR   = 4;
	localparam int FLD_DSS   = 5;
	localparam int FLD_DTT   = 6;
	localparam int FLD_DRS   = 7;
	localparam int FLD_DST   = 8;
	localparam int FLD_DRT   = 9;

	// node order: bottom corners, top corners, bottom edges, top edges, vertical edges
	typedef enum logic [NODE_W-1:0] {
		NODE_B0, NODE_B1, NODE_B2,
		NODE_T0, NODE_T1, NODE_T2,
		NODE_EB0, NODE_EB1, NODE_EB2,
		NODE_ET0, NODE_ET1, NODE_ET2,
		NODE_V0, NODE_V1, NODE_V2
	} node_t;

	typedef struct packed {
		logic  valid;
		node_t node;
	} tag_t;

endpackage

// ===== hw/rtl/wsf_issue.sv =====
module wsf_issue import wsf_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [COORD_W-1:0] r_in,
	input  logic signed [COORD_W-1:0] s_in,
	input  logic signed [COORD_W-1:0] t_in,
	output tag_t                      tag_out,
	input  logic                      ready_out,
	output logic signed [COORD_W-1:0] r_q,
	output logic signed [COORD_W-1:0] s_q,
	output logic signed [COORD_W-1:0] t_q
);

	logic  busy_q;
	node_t cnt_q;
	logic  issue;
	logic  last;

	assign issue         = busy_q && ready_out;
	assign last          = (cnt_q == NODE_V2);
	assign in_ready      = !busy_q || (ready_out && last);
	assign tag_out.valid = busy_q;
	assign tag_out.node  = cnt_q;

	// walk the node counter; take a new coordinate once the last node leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= NODE_B0;
		end else begin
			if (issue) begin
				cnt_q  <= last ? NODE_B0 : node_t'(cnt_q + 4'd1);
				busy_q <= !last;
			end
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
				cnt_q  <= NODE_B0;
			end
		end
	end

	// hold the coordinate for all fifteen nodes
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			r_q <= r_in;
			s_q <= s_in;
			t_q <= t_in;
		end
	end

endmodule

// ===== hw/rtl/wsf_stage1.sv =====
module wsf_stage1 import wsf_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	localparam int XB = (FRAC_BITS > MIN_WIDE) ? FRAC_BITS : MIN_WIDE,
	localparam int VW = 3 * XB - 2 * FRAC_BITS + 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tag_t                      tag_in,
	output logic                      ready_in,
	input  logic signed [COORD_W-1:0] r_in,
	input  logic signed [COORD_W-1:0] s_in,
	input  logic signed [COORD_W-1:0] t_in,
	output tag_t                      tag_s1,
	input  logic                      ready_out,
	output logic signed [COORD_W-1:0] r_s1,
	output logic signed [COORD_W-1:0] s_s1,
	output logic signed [COORD_W-1:0] t_s1,
	output logic signed [VW-1:0]      tt_s1,
	output logic signed [VW-1:0]      pb_s1,
	output logic signed [VW-1:0]      pc_s1,
	output logic signed [VW-1:0]      pd_s1
);

	localparam int LW = XB + 5;
	localparam int PW = 2 * LW;

	logic signed [LW-1:0] rl, sl, tl, one, h, u, w, tn;
	logic signed [LW-1:0] b_a, b_b, c_a, c_b, d_a;
	logic                 c_half;
	logic signed [PW-1:0] pb, pc, pd, pt;

	function automatic logic signed [VW-1:0] rnd(input logic signed [PW-1:0] p,
			input logic half);
		logic signed [PW-1:0] bias;
		logic signed [PW-1:0] sum;
		bias = half ? (PW'(1) <<< FRAC_BITS) : (PW'(1) <<< (FRAC_BITS - 1));
		sum  = p + bias;
		return half ? VW'(sum >>> (FRAC_BITS + 1)) : VW'(sum >>> FRAC_BITS);
	endfunction

	assign rl  = LW'(r_in);
	assign sl  = LW'(s_in);
	assign tl  = LW'(t_in);
	assign one = LW'(1) <<< FRAC_BITS;
	assign h   = one >>> 1;
	assign u   = one - rl - sl;
	assign w   = rl + sl - one;
	assign tn  = tl - one;

	// pick the first-level product operands for this node
	always_comb begin
		b_a    = '0;
		b_b    = '0;
		c_a    = '0;
		c_b    = '0;
		c_half = 1'b0;
		d_a    = (tag_in.node == NODE_B2) ? sl : rl;
		case (tag_in.node)
			NODE_B0: begin
				b_a = u; b_b = 2 * u - one;
				c_a = w; c_b = 2 * rl + 2 * sl + 2 * tl - one; c_half = 1'b1;
			end
			NODE_B1: begin
				b_a = rl; b_b = 2 * rl - one;
				c_a = rl; c_b = one - 2 * rl + 2 * tl; c_half = 1'b1;
			end
			NODE_B2: begin
				b_a = sl; b_b = 2 * sl - one;
				c_a = sl; c_b = one - 2 * sl + 2 * tl; c_half = 1'b1;
			end
			NODE_T0: begin
				b_a = u; b_b = 2 * u - one;
				c_a = w; c_b = 2 * rl + 2 * sl - 2 * tl - one; c_half = 1'b1;
			end
			NODE_T1: begin
				b_a = rl; b_b = 2 * rl - one;
				c_a = rl; c_b = rl + tl - h;
			end
			NODE_T2: begin
				b_a = sl; b_b = 2 * sl - one;
				c_a = sl; c_b = sl + tl - h;
			end
			NODE_EB0, NODE_ET0: begin
				b_a = rl; b_b = u;
				c_a = rl; c_b = w;
			end
			NODE_EB1, NODE_ET1: begin
				b_a = rl; b_b = sl;
				c_a = rl; c_b = sl;
			end
			NODE_EB2, NODE_ET2: begin
				b_a = sl; b_b = u;
				c_a = sl; c_b = w;
			end
			NODE_V0: begin
				c_a = w; c_b = tl;
			end
			NODE_V1: begin
				c_a = rl; c_b = tl;
			end
			NODE_V2: begin
				c_a = sl; c_b = tl;
			end
			default: begin
				b_a = '0;
			end
		endcase
	end

	assign pb = PW'(b_a) * PW'(b_b);
	assign pc = PW'(c_a) * PW'(c_b);
	assign pd = PW'(d_a) * PW'(tn);
	assign pt = PW'(tl) * PW'(tl);

	assign ready_in = !tag_s1.valid || ready_out;

	// advance the control tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (ready_in) begin
			tag_s1 <= tag_in;
		end
	end

	// register products and carry the coordinate
	always_ff @(posedge clk) begin
		if (ready_in && tag_in.valid) begin
			r_s1  <= r_in;
			s_s1  <= s_in;
			t_s1  <= t_in;
			tt_s1 <= rnd(pt, 1'b0);
			pb_s1 <= rnd(pb, 1'b0);
			pc_s1 <= rnd(pc, c_half);
			pd_s1 <= rnd(pd, 1'b0);
		end
	end

endmodule

// ===== hw/rtl/wsf_stage2.sv =====
module wsf_stage2 import wsf_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	localparam int XB = (FRAC_BITS > MIN_WIDE) ? FRAC_BITS : MIN_WIDE,
	localparam int VW = 3 * XB - 2 * FRAC_BITS + 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tag_t                      tag_in,
	output logic                      ready_in,
	input  logic signed [COORD_W-1:0] r_in,
	input  logic signed [COORD_W-1:0] s_in,
	input  logic signed [COORD_W-1:0] t_in,
	input  logic signed [VW-1:0]      tt_in,
	input  logic signed [VW-1:0]      pb_in,
	input  logic signed [VW-1:0]      pc_in,
	input  logic signed [VW-1:0]      pd_in,
	output tag_t                      tag_s2,
	input  logic                      ready_out,
	output logic signed [COORD_W-1:0] r_s2,
	output logic signed [COORD_W-1:0] s_s2,
	output logic signed [COORD_W-1:0] t_s2,
	output logic signed [VW-1:0]      tt_s2,
	output logic signed [VW-1:0]      pc_s2,
	output logic signed [VW-1:0]      pd_s2,
	output logic signed [VW-1:0]      pn_s2,
	output logic signed [VW-1:0]      pq_s2,
	output logic signed [VW-1:0]      pr_s2,
	output logic signed [VW-1:0]      ps_s2
);

	localparam int PW = 2 * VW;

	logic signed [VW-1:0] rl, sl, tl, one, u, tm, tp, tn, e1, e2, ra, rb, q;
	logic signed [VW-1:0] n_a, n_b, q_b, r_a, r_b, s_a, s_b;
	logic                 n_half, q_half, r_half, s_half;
	logic signed [PW-1:0] pn, pq, pr, ps;

	function automatic logic signed [VW-1:0] rnd(input logic signed [PW-1:0] p,
			input logic half);
		logic signed [PW-1:0] bias;
		logic signed [PW-1:0] sum;
		bias = half ? (PW'(1) <<< FRAC_BITS) : (PW'(1) <<< (FRAC_BITS - 1));
		sum  = p + bias;
		return half ? VW'(sum >>> (FRAC_BITS + 1)) : VW'(sum >>> FRAC_BITS);
	endfunction

	assign rl  = VW'(r_in);
	assign sl  = VW'(s_in);
	assign tl  = VW'(t_in);
	assign one = VW'(1) <<< FRAC_BITS;
	assign u   = one - rl - sl;
	assign tm  = one - tl;
	assign tp  = one + tl;
	assign tn  = tl - one;
	assign e1  = 2 * rl + sl - one;
	assign e2  = rl + 2 * sl - one;
	assign ra  = 4 * rl + 4 * sl + tl - 2 * one;
	assign rb  = 4 * rl + 4 * sl - tl - 2 * one;
	assign q   = one - tt_in;

	// pick the second-level product operands for this node
	always_comb begin
		n_a    = pb_in;
		n_b    = '0;
		n_half = 1'b0;
		q_b    = '0;
		q_half = 1'b1;
		r_a    = '0;
		r_b    = '0;
		r_half = 1'b0;
		s_a    = '0;
		s_b    = '0;
		s_half = 1'b0;
		case (tag_in.node)
			NODE_B0: begin
				n_b = tm; n_half = 1'b1; q_b = u;
				r_a = tm; r_b = ra; r_half = 1'b1;
				s_a = tm; s_b = ra; s_half = 1'b1;
			end
			NODE_B1: begin
				n_b = tm; n_half = 1'b1; q_b = rl;
			end
			NODE_B2: begin
				n_b = tm; n_half = 1'b1; q_b = sl;
			end
			NODE_T0: begin
				n_b = tp; n_half = 1'b1; q_b = u;
				r_a = rb; r_b = tp; r_half = 1'b1;
				s_a = rb; s_b = tp; s_half = 1'b1;
			end
			NODE_T1: begin
				n_b = tp; n_half = 1'b1; q_b = rl;
				r_a = tp; r_b = 4 * rl + tl - 2 * one; r_half = 1'b1;
			end
			NODE_T2: begin
				n_b = tp; n_half = 1'b1; q_b = sl;
				s_a = tp; s_b = 4 * sl + tl - 2 * one; s_half = 1'b1;
			end
			NODE_EB0: begin
				n_b = tm;
				r_a = e1; r_b = tn;
				s_a = rl; s_b = tn;
			end
			NODE_EB1: begin
				n_b = tm;
				r_a = sl; r_b = tn;
				s_a = rl; s_b = tn;
			end
			NODE_EB2: begin
				n_b = tm;
				r_a = sl; r_b = tn;
				s_a = e2; s_b = tn;
			end
			NODE_ET0: begin
				n_b = tp;
				r_a = e1; r_b = tp;
				s_a = rl; s_b = tp;
			end
			NODE_ET1: begin
				n_b = tp;
				r_a = sl; r_b = tp;
				s_a = rl; s_b = tp;
			end
			NODE_ET2: begin
				n_b = tp;
				r_a = sl; r_b = tp;
				s_a = e2; s_b = tp;
			end
			NODE_V0: begin
				n_a = q; n_b = u;
			end
			NODE_V1: begin
				n_a = q; n_b = rl;
			end
			NODE_V2: begin
				n_a = q; n_b = sl;
			end
			default: begin
				n_b = '0;
			end
		endcase
	end

	assign pn = PW'(n_a) * PW'(n_b);
	assign pq = PW'(q) * PW'(q_b);
	assign pr = PW'(r_a) * PW'(r_b);
	assign ps = PW'(s_a) * PW'(s_b);

	assign ready_in = !tag_s2.valid || ready_out;

	// advance the control tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else if (ready_in) begin
			tag_s2 <= tag_in;
		end
	end

	// register products and carry earlier terms
	always_ff @(posedge clk) begin
		if (ready_in && tag_in.valid) begin
			r_s2  <= r_in;
			s_s2  <= s_in;
			t_s2  <= t_in;
			tt_s2 <= tt_in;
			pc_s2 <= pc_in;
			pd_s2 <= pd_in;
			pn_s2 <= rnd(pn, n_half);
			pq_s2 <= rnd(pq, q_half);
			pr_s2 <= rnd(pr, r_half);
			ps_s2 <= rnd(ps, s_half);
		end
	end

endmodule

// ===== hw/rtl/wsf_stage3.sv =====
module wsf_stage3 import wsf_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	localparam int XB = (FRAC_BITS > MIN_WIDE) ? FRAC_BITS : MIN_WIDE,
	localparam int VW = 3 * XB - 2 * FRAC_BITS + 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tag_t                                tag_in,
	output logic                                ready_in,
	input  logic signed [COORD_W-1:0]           r_in,
	input  logic signed [COORD_W-1:0]           s_in,
	input  logic signed [COORD_W-1:0]           t_in,
	input  logic signed [VW-1:0]                tt_in,
	input  logic signed [VW-1:0]                pc_in,
	input  logic signed [VW-1:0]                pd_in,
	input  logic signed [VW-1:0]                pn_in,
	input  logic signed [VW-1:0]                pq_in,
	input  logic signed [VW-1:0]                pr_in,
	input  logic signed [VW-1:0]                ps_in,
	output tag_t                                tag_s3,
	input  logic                                ready_out,
	output logic [NUM_FIELDS-1:0][OUT_W-1:0]    fld_s3
);

	localparam int SW = VW + 4;

	logic signed [SW-1:0] rl, sl, tl, one, h, u, w, tm, tp, tn, e1, e2;
	logic signed [SW-1:0] tt, c, n2, q2, r2, s2, hr, hs;
	logic signed [SW-1:0] v [NUM_FIELDS];

	function automatic logic [OUT_W-1:0] sat(input logic signed [SW-1:0] x);
		if (x > SW'(OUT_MAX)) begin
			return OUT_W'(OUT_MAX);
		end else if (x < SW'(OUT_MIN)) begin
			return OUT_W'(OUT_MIN);
		end
		return OUT_W'(x);
	endfunction

	assign rl  = SW'(r_in);
	assign sl  = SW'(s_in);
	assign tl  = SW'(t_in);
	assign one = SW'(1) <<< FRAC_BITS;
	assign h   = one >>> 1;
	assign u   = one - rl - sl;
	assign w   = rl + sl - one;
	assign tm  = one - tl;
	assign tp  = one + tl;
	assign tn  = tl - one;
	assign e1  = 2 * rl + sl - one;
	assign e2  = rl + 2 * sl - one;
	assign tt  = SW'(tt_in);
	assign c   = SW'(pc_in);
	assign n2  = SW'(pn_in);
	assign q2  = SW'(pq_in);
	assign r2  = SW'(pr_in);
	assign s2  = SW'(ps_in);
	// halved corner derivatives, rounded up on ties
	assign hr  = (-2 * one - 4 * SW'(pd_in) + tl + tt + SW'(1)) >>> 1;
	assign hs  = hr;

	// combine terms into the ten field values of this node
	always_comb begin
		for (int i = 0; i < NUM_FIELDS; i++) begin
			v[i] = '0;
		end
		case (tag_in.node)
			NODE_B0: begin
				v[FLD_SHAPE] = n2 - q2;
				v[FLD_DR] = r2; v[FLD_DS] = s2; v[FLD_DT] = -c;
				v[FLD_DRR] = 2 * tm; v[FLD_DSS] = 2 * tm; v[FLD_DTT] = u;
				v[FLD_DRS] = 2 * tm;
				v[FLD_DST] = 3 * h - 2 * rl - 2 * sl - tl;
				v[FLD_DRT] = 3 * h - 2 * rl - 2 * sl - tl;
			end
			NODE_B1: begin
				v[FLD_SHAPE] = n2 - q2;
				v[FLD_DR] = hr; v[FLD_DT] = c;
				v[FLD_DRR] = 2 * tm; v[FLD_DTT] = rl;
				v[FLD_DRT] = h - 2 * rl + tl;
			end
			NODE_B2: begin
				v[FLD_SHAPE] = n2 - q2;
				v[FLD_DS] = hs; v[FLD_DT] = c;
				v[FLD_DSS] = 2 * tm; v[FLD_DTT] = sl;
				v[FLD_DST] = h - 2 * sl + tl;
			end
			NODE_T0: begin
				v[FLD_SHAPE] = n2 - q2;
				v[FLD_DR] = r2; v[FLD_DS] = s2; v[FLD_DT] = c;
				v[FLD_DRR] = 2 * tp; v[FLD_DSS] = 2 * tp; v[FLD_DTT] = u;
				v[FLD_DRS] = 2 * tp;
				v[FLD_DST] = -3 * h + 2 * rl + 2 * sl - tl;
				v[FLD_DRT] = -3 * h + 2 * rl + 2 * sl - tl;
			end
			NODE_T1: begin
				v[FLD_SHAPE] = n2 - q2;
				v[FLD_DR] = r2; v[FLD_DT] = c;
				v[FLD_DRR] = 2 * tp; v[FLD_DTT] = rl;
				v[FLD_DRT] = -h + 2 * rl + tl;
			end
			NODE_T2: begin
				v[FLD_SHAPE] = n2 - q2;
				v[FLD_DS] = s2; v[FLD_DT] = c;
				v[FLD_DSS] = 2 * tp; v[FLD_DTT] = sl;
				v[FLD_DST] = -h + 2 * sl + tl;
			end
			NODE_EB0: begin
				v[FLD_SHAPE] = 2 * n2;
				v[FLD_DR] = 2 * r2; v[FLD_DS] = 2 * s2; v[FLD_DT] = 2 * c;
				v[FLD_DRR] = 4 * tn; v[FLD_DRS] = 2 * tn;
				v[FLD_DST] = 2 * rl; v[FLD_DRT] = 2 * e1;
			end
			NODE_EB1: begin
				v[FLD_SHAPE] = 2 * n2;
				v[FLD_DR] = -2 * r2; v[FLD_DS] = -2 * s2; v[FLD_DT] = -2 * c;
				v[FLD_DRS] = 2 * tm;
				v[FLD_DST] = -2 * rl; v[FLD_DRT] = -2 * sl;
			end
			NODE_EB2: begin
				v[FLD_SHAPE] = 2 * n2;
				v[FLD_DR] = 2 * r2; v[FLD_DS] = 2 * s2; v[FLD_DT] = 2 * c;
				v[FLD_DSS] = 4 * tn; v[FLD_DRS] = 2 * tn;
				v[FLD_DST] = 2 * e2; v[FLD_DRT] = 2 * sl;
			end
			NODE_ET0: begin
				v[FLD_SHAPE] = 2 * n2;
				v[FLD_DR] = -2 * r2; v[FLD_DS] = -2 * s2; v[FLD_DT] = -2 * c;
				v[FLD_DRR] = -4 * tp; v[FLD_DRS] = -2 * tp;
				v[FLD_DST] = -2 * rl; v[FLD_DRT] = -2 * e1;
			end
			NODE_ET1: begin
				v[FLD_SHAPE] = 2 * n2;
				v[FLD_DR] = 2 * r2; v[FLD_DS] = 2 * s2; v[FLD_DT] = 2 * c;
				v[FLD_DRS] = 2 * tp;
				v[FLD_DST] = 2 * rl; v[FLD_DRT] = 2 * sl;
			end
			NODE_ET2: begin
				v[FLD_SHAPE] = 2 * n2;
				v[FLD_DR] = -2 * r2; v[FLD_DS] = -2 * s2; v[FLD_DT] = -2 * c;
				v[FLD_DSS] = -4 * tp; v[FLD_DRS] = -2 * tp;
				v[FLD_DST] = -2 * e2; v[FLD_DRT] = -2 * sl;
			end
			NODE_V0: begin
				v[FLD_SHAPE] = n2;
				v[FLD_DR] = tt - one; v[FLD_DS] = tt - one; v[FLD_DT] = 2 * c;
				v[FLD_DTT] = 2 * w;
				v[FLD_DST] = 2 * tl; v[FLD_DRT] = 2 * tl;
			end
			NODE_V1: begin
				v[FLD_SHAPE] = n2;
				v[FLD_DR] = one - tt; v[FLD_DT] = -2 * c;
				v[FLD_DTT] = -2 * rl; v[FLD_DRT] = -2 * tl;
			end
			NODE_V2: begin
				v[FLD_SHAPE] = n2;
				v[FLD_DS] = one - tt; v[FLD_DT] = -2 * c;
				v[FLD_DTT] = -2 * sl; v[FLD_DST] = -2 * tl;
			end
			default: begin
				v[FLD_SHAPE] = '0;
			end
		endcase
	end

	assign ready_in = !tag_s3.valid || ready_out;

	// advance the control tag into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
		end else if (ready_in) begin
			tag_s3 <= tag_in;
		end
	end

	// saturate and hold the result until its transfer
	always_ff @(posedge clk) begin
		if (ready_in && tag_in.valid) begin
			for (int i = 0; i < NUM_FIELDS; i++) begin
				fld_s3[i] <= sat(v[i]);
			end
		end
	end

endmodule

// ===== hw/rtl/wedge15_shape_function_eval.sv =====
// A coordinate is held in wsf_issue; its results pass the stage1, stage2 and stage3 registers.
// One result per cycle while the receiver does not stall, fifteen results per
// coordinate, all on the single result channel.
// The next coordinate is taken while the current one's last node issues.
// Reset: arst_n clears all valid and control state asynchronously.
module wedge15_shape_function_eval import wsf_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	localparam int XB = (FRAC_BITS > MIN_WIDE) ? FRAC_BITS : MIN_WIDE,
	localparam int VW = 3 * XB - 2 * FRAC_BITS + 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// r_coord[15:0], s_coord[31:16], t_coord[47:32]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// node_index, shape_value, d_r, d_s, d_t, d_rr, d_ss, d_tt, d_rs, d_st, d_rt,
	// then four zero bits
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tlast
);

	tag_t tag_i, tag_s1, tag_s2, tag_s3;
	logic rdy1, rdy2, rdy3;
	logic signed [COORD_W-1:0] r_i, s_i, t_i, r_s1, s_s1, t_s1, r_s2, s_s2, t_s2;
	logic signed [VW-1:0] tt_s1, pb_s1, pc_s1, pd_s1;
	logic signed [VW-1:0] tt_s2, pc_s2, pd_s2, pn_s2, pq_s2, pr_s2, ps_s2;
	logic [NUM_FIELDS-1:0][OUT_W-1:0] fld_s3;

	wsf_issue u_issue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.r_in      (s_tdata[15:0]),
		.s_in      (s_tdata[31:16]),
		.t_in      (s_tdata[47:32]),
		.tag_out   (tag_i),
		.ready_out (rdy1),
		.r_q       (r_i),
		.s_q       (s_i),
		.t_q       (t_i)
	);

	wsf_stage1 #(.FRAC_BITS(FRAC_BITS)) u_stage1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_in    (tag_i),
		.ready_in  (rdy1),
		.r_in      (r_i),
		.s_in      (s_i),
		.t_in      (t_i),
		.tag_s1    (tag_s1),
		.ready_out (rdy2),
		.r_s1      (r_s1),
		.s_s1      (s_s1),
		.t_s1      (t_s1),
		.tt_s1     (tt_s1),
		.pb_s1     (pb_s1),
		.pc_s1     (pc_s1),
		.pd_s1     (pd_s1)
	);

	wsf_stage2 #(.FRAC_BITS(FRAC_BITS)) u_stage2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_in    (tag_s1),
		.ready_in  (rdy2),
		.r_in      (r_s1),
		.s_in      (s_s1),
		.t_in      (t_s1),
		.tt_in     (tt_s1),
		.pb_in     (pb_s1),
		.pc_in     (pc_s1),
		.pd_in     (pd_s1),
		.tag_s2    (tag_s2),
		.ready_out (rdy3),
		.r_s2      (r_s2),
		.s_s2      (s_s2),
		.t_s2      (t_s2),
		.tt_s2     (tt_s2),
		.pc_s2     (pc_s2),
		.pd_s2     (pd_s2),
		.pn_s2     (pn_s2),
		.pq_s2     (pq_s2),
		.pr_s2     (pr_s2),
		.ps_s2     (ps_s2)
	);

	wsf_stage3 #(.FRAC_BITS(FRAC_BITS)) u_stage3 (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_in    (tag_s2),
		.ready_in  (rdy3),
		.r_in      (r_s2),
		.s_in      (s_s2),
		.t_in      (t_s2),
		.tt_in     (tt_s2),
		.pc_in     (pc_s2),
		.pd_in     (pd_s2),
		.pn_in     (pn_s2),
		.pq_in     (pq_s2),
		.pr_in     (pr_s2),
		.ps_in     (ps_s2),
		.tag_s3    (tag_s3),
		.ready_out (m_tready),
		.fld_s3    (fld_s3)
	);

	// pack the output register onto the result stream
	assign m_tvalid = tag_s3.valid;
	assign m_tlast  = (tag_s3.node == NODE_V2);
	assign m_tdata  = {4'b0000, fld_s3, tag_s3.node};

endmodule

// ===== verif/wedge15_shape_function_eval_tb.sv =====
`timescale 1ns / 1ps

module wedge15_shape_function_eval_tb;
	import wsf_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int NODES = 15;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [COORD_W-1:0] t;
		logic signed [COORD_W-1:0] s;
		logic signed [COORD_W-1:0] r;
	} coord_t;

	typedef struct {
		logic [NODE_W-1:0] node;
		logic [OUT_W-1:0]  f [NUM_FIELDS];
		logic              last;
	} node_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;

	coord_t       coord_q [$];
	node_result_t node_exp_q [$];
	int           mismatch_cnt;
	int           sender_idle_pct;
	int           receiver_stall_pct;
	int           hold_cycles;
	longint       cycle_cnt;
	bit           in_acc_q;

	wedge15_shape_function_eval dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// round to nearest, ties toward plus infinity
	function automatic longint round_shift(longint x, int k);
		return (x + (longint'(1) << (k - 1))) >>> k;
	endfunction

	function automatic longint fmul(longint a, longint b);
		return round_shift(a * b, FB);
	endfunction

	function automatic longint fmul_half(longint a, longint b);
		return round_shift(a * b, FB + 1);
	endfunction

	function automatic logic [OUT_W-1:0] clamp20(longint v);
		if (v > OUT_MAX) v = OUT_MAX;
		if (v < OUT_MIN) v = OUT_MIN;
		return v[OUT_W-1:0];
	endfunction

	// expand one coordinate into its fifteen node results
	task automatic predict_wedge_nodes(coord_t c);
		longint r, s, t, one, h, u, w, tm, tp, tn, tt, q, a, br, bs;
		longint qu2, qr2, qs2, ru, rs, su, e1, e2, ra, rb;
		longint v [NUM_FIELDS][NODES];
		node_result_t res;
		r = c.r; s = c.s; t = c.t;
		one = longint'(1) << FB;
		h = longint'(1) << (FB - 1);
		u = one - r - s; w = r + s - one;
		tm = one - t; tp = one + t; tn = t - one;
		tt = fmul(t, t); q = one - tt;
		a = fmul(u, 2 * u - one); br = fmul(r, 2 * r - one); bs = fmul(s, 2 * s - one);
		qu2 = fmul_half(q, u); qr2 = fmul_half(q, r); qs2 = fmul_half(q, s);
		ru = fmul(r, u); rs = fmul(r, s); su = fmul(s, u);
		e1 = 2 * r + s - one; e2 = r + 2 * s - one;
		ra = 4 * r + 4 * s + t - 2 * one; rb = 4 * r + 4 * s - t - 2 * one;
		v[FLD_SHAPE] = '{fmul_half(tm, a) - qu2, fmul_half(br, tm) - qr2,
			fmul_half(bs, tm) - qs2, fmul_half(tp, a) - qu2, fmul_half(br, tp) - qr2,
			fmul_half(bs, tp) - qs2, 2 * fmul(ru, tm), 2 * fmul(rs, tm), 2 * fmul(su, tm),
			2 * fmul(ru, tp), 2 * fmul(rs, tp), 2 * fmul(su, tp),
			fmul(q, u), fmul(r, q), fmul(s, q)};
		v[FLD_DR] = '{fmul_half(tm, ra), round_shift(-2 * one - 4 * fmul(r, tn) + t + tt, 1),
			0, fmul_half(rb, tp), fmul_half(tp, 4 * r + t - 2 * one), 0,
			2 * fmul(e1, tn), -2 * fmul(s, tn), 2 * fmul(s, tn),
			-2 * fmul(e1, tp), 2 * fmul(s, tp), -2 * fmul(s, tp), tt - one, one - tt, 0};
		v[FLD_DS] = '{fmul_half(tm, ra), 0,
			round_shift(-2 * one - 4 * fmul(s, tn) + t + tt, 1),
			fmul_half(rb, tp), 0, fmul_half(tp, 4 * s + t - 2 * one),
			2 * fmul(r, tn), -2 * fmul(r, tn), 2 * fmul(e2, tn),
			-2 * fmul(r, tp), 2 * fmul(r, tp), -2 * fmul(e2, tp), tt - one, 0, one - tt};
		v[FLD_DT] = '{-fmul_half(w, 2 * r + 2 * s + 2 * t - one),
			fmul_half(r, one - 2 * r + 2 * t), fmul_half(s, one - 2 * s + 2 * t),
			fmul_half(w, 2 * r + 2 * s - 2 * t - one),
			fmul(r, r + t - h), fmul(s, s + t - h),
			2 * fmul(r, w), -2 * rs, 2 * fmul(s, w),
			-2 * fmul(r, w), 2 * rs, -2 * fmul(s, w),
			2 * fmul(w, t), -2 * fmul(r, t), -2 * fmul(s, t)};
		v[FLD_DRR] = '{2 * tm, 2 * tm, 0, 2 * tp, 2 * tp, 0, 4 * tn, 0, 0, -4 * tp,
			0, 0, 0, 0, 0};
		v[FLD_DSS] = '{2 * tm, 0, 2 * tm, 2 * tp, 0, 2 * tp, 0, 0, 4 * tn, 0, 0, -4 * tp,
			0, 0, 0};
		v[FLD_DTT] = '{u, r, s, u, r, s, 0, 0, 0, 0, 0, 0, 2 * w, -2 * r, -2 * s};
		v[FLD_DRS] = '{2 * tm, 0, 0, 2 * tp, 0, 0, 2 * tn, 2 * tm, 2 * tn, -2 * tp,
			2 * tp, -2 * tp, 0, 0, 0};
		v[FLD_DST] = '{3 * h - 2 * r - 2 * s - t, 0, h - 2 * s + t,
			-3 * h + 2 * r + 2 * s - t, 0, -h + 2 * s + t,
			2 * r, -2 * r, 2 * e2, -2 * r, 2 * r, -2 * e2, 2 * t, 0, -2 * t};
		v[FLD_DRT] = '{3 * h - 2 * r - 2 * s - t, h - 2 * r + t, 0,
			-3 * h + 2 * r + 2 * s - t, -h + 2 * r + t, 0,
			2 * e1, -2 * s, 2 * s, -2 * e1, 2 * s, -2 * s, 2 * t, -2 * t, 0};
		for (int k = 0; k < NODES; k++) begin
			res.node = k[NODE_W-1:0];
			for (int j = 0; j < NUM_FIELDS; j++)
				res.f[j] = clamp20(v[j][k]);
			res.last = (k == NODES - 1);
			node_exp_q.push_back(res);
		end
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH t=%0t %s got %0h want %0h", $realtime, what, got, want);
		mismatch_cnt++;
	endtask

	function automatic logic signed [COORD_W-1:0] rand_coord();
		int sel;
		sel = $urandom_range(0, 9);
		// mostly inside or near the element, sometimes anywhere in range
		if (sel < 6) return COORD_W'($urandom_range(0, 1 << FB) - 0);
		if (sel < 8) return COORD_W'(int'($urandom_range(0, 4 << FB)) - (2 << FB));
		return COORD_W'($urandom);
	endfunction

	function automatic coord_t make_coord(int r, int s, int t);
		coord_t c;
		c.r = COORD_W'(r); c.s = COORD_W'(s); c.t = COORD_W'(t);
		return c;
	endfunction

	// drive coordinates on the falling edge; advance after a transfer at the rising edge
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (in_acc_q) begin
				predict_wedge_nodes(coord_q.pop_front());
			end
			if (!s_tvalid || in_acc_q) begin
				if (coord_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= coord_q[0];
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver backpressure
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
		end
	end

	// note input transfers; check each result transfer against the oldest expectation
	always @(posedge clk) begin
		node_result_t exp_res;
		logic [OUT_W-1:0] got_f;
		cycle_cnt <= cycle_cnt + 1;
		in_acc_q  <= arst_n && s_tvalid && s_tready;
		if (arst_n && m_tvalid && m_tready) begin
			if (node_exp_q.size() == 0) begin
				report_mismatch("unexpected result node", m_tdata[NODE_W-1:0], 0);
			end else begin
				exp_res = node_exp_q.pop_front();
				if (m_tdata[NODE_W-1:0] !== exp_res.node)
					report_mismatch("node_index", m_tdata[NODE_W-1:0], exp_res.node);
				for (int j = 0; j < NUM_FIELDS; j++) begin
					got_f = m_tdata[NODE_W + j * OUT_W +: OUT_W];
					if (got_f !== exp_res.f[j])
						report_mismatch($sformatf("node %0d field %0d", exp_res.node, j),
							got_f, exp_res.f[j]);
				end
				if (m_tlast !== exp_res.last)
					report_mismatch("last_node", m_tlast, exp_res.last);
			end
		end
	end

	// stop on runaway
	always @(posedge clk) begin
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic wait_drained();
		while (coord_q.size() > 0 || s_tvalid || node_exp_q.size() > 0)
			@(posedge clk);
	endtask

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++)
			coord_q.push_back(make_coord(rand_coord(), rand_coord(), rand_coord()));
	endtask

	initial begin
		int one;
		one = 1 << FB;
		mismatch_cnt = 0;
		cycle_cnt = 0;
		hold_cycles = 0;
		in_acc_q = 1'b0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// corners, mid-edges, centroid, field extremes and bit patterns
		coord_q.push_back(make_coord(0, 0, -one));
		coord_q.push_back(make_coord(one, 0, -one));
		coord_q.push_back(make_coord(0, one, one));
		coord_q.push_back(make_coord(one / 2, one / 2, 0));
		coord_q.push_back(make_coord(one / 2, 0, one));
		coord_q.push_back(make_coord(0, one / 2, 0));
		coord_q.push_back(make_coord(one / 3, one / 3, 0));
		coord_q.push_back(make_coord(32767, 32767, 32767));
		coord_q.push_back(make_coord(-32768, -32768, -32768));
		coord_q.push_back(make_coord(32767, -32768, 32767));
		coord_q.push_back(make_coord(-32768, 32767, -32768));
		coord_q.push_back(make_coord(0, 0, 0));
		coord_q.push_back(make_coord(-1, -1, -1));
		coord_q.push_back(make_coord(16'h5555, 16'h2aaa, 16'h5555));
		coord_q.push_back(make_coord(16'haaaa, 16'hd555, 16'haaaa));
		coord_q.push_back(make_coord(1, 1, 1));
		wait_drained();

		// no idling
		queue_random(50);
		wait_drained();
		// sender idle, then let everything drain before the next phase
		sender_idle_pct = 64;
		queue_random(50);
		wait_drained();
		// receiver stalls, with one long hold-off while input keeps coming
		sender_idle_pct = 0;
		receiver_stall_pct = 64;
		queue_random(10);
		@(negedge clk);
		hold_cycles = 300;
		queue_random(40);
		wait_drained();
		// both
		sender_idle_pct = 28;
		receiver_stall_pct = 28;
		queue_random(55);
		wait_drained();

		repeat (20) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== wedge15_shape_function_eval.f =====
hw/rtl/wsf_pkg.sv
hw/rtl/wsf_issue.sv
hw/rtl/wsf_stage1.sv
hw/rtl/wsf_stage2.sv
hw/rtl/wsf_stage3.sv
hw/rtl/wedge15_shape_function_eval.sv
verif/wedge15_shape_function_eval_tb.sv
